[hdl/scsr_pkg.sv]
// ----------------------------------------------------------------------------
// scsr_pkg
// Types, constants and helpers shared by the conversion sequencer and ring.
// ----------------------------------------------------------------------------
package scsr_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PERIOD_W   = 16;
  localparam int DELAY_W    = 7;
  localparam int RETRY_W    = 3;
  localparam int MAXP_W     = 5;
  localparam int POINTS_W   = 4;
  localparam int CMD_W      = 3;
  localparam int PHASE_W    = 2;

  localparam int RING_DEPTH = 16;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CMP_W      = (PTR_W > MAXP_W) ? PTR_W : MAXP_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MAXP_W-1:0]   MAX_POINTS   = MAXP_W'(16);
  localparam logic [RETRY_W-1:0]  RETRY_MAX    = RETRY_W'(5);
  localparam logic [DELAY_W-1:0]  DELAY_LONG   = DELAY_W'(100);
  localparam logic [DELAY_W-1:0]  DELAY_SHORT  = DELAY_W'(10);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

  // bit positions in commands_issued
  localparam int CMD_START = 0;
  localparam int CMD_POLL  = 1;
  localparam int CMD_READ  = 2;

  // reported conversion state codes
  localparam logic [PHASE_W-1:0] CODE_IDLE     = 2'd0;
  localparam logic [PHASE_W-1:0] CODE_STARTING = 2'd1;
  localparam logic [PHASE_W-1:0] CODE_STARTED  = 2'd2;
  localparam logic [PHASE_W-1:0] CODE_COMPLETE = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_STARTING = 4'b0010,
    PH_STARTED  = 4'b0100,
    PH_COMPLETE = 4'b1000
  } phase_e;

  typedef struct packed {
    op_e                        op;
    logic                       start_ok;
    logic                       ready_ok;
    logic                       read_ok;
    logic signed [SAMPLE_W-1:0] raw_sample;
    logic [MAXP_W-1:0]          lim;
  } item_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] held_count(input logic [PTR_W-1:0] wr,
                                                  input logic [PTR_W-1:0] rd);
    logic [PTR_W:0] sum;
    sum = {1'b0, wr} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, rd};
    if (wr >= rd) begin
      return wr - rd;
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PHASE_W-1:0] phase_code(input phase_e ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      PH_IDLE:     code = CODE_IDLE;
      PH_STARTING: code = CODE_STARTING;
      PH_STARTED:  code = CODE_STARTED;
      PH_COMPLETE: code = CODE_COMPLETE;
      default:     code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

[hdl/scsr_in_if.sv]
// ----------------------------------------------------------------------------
// scsr_in_if
// Input channel: one request item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scsr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           op;
  logic                                 start_ok;
  logic                                 ready_ok;
  logic                                 read_ok;
  logic signed [scsr_pkg::SAMPLE_W-1:0] raw_sample;
  logic [scsr_pkg::MAXP_W-1:0]          req_points;

  modport source (
    output valid, op, start_ok, ready_ok, read_ok, raw_sample, req_points,
    input  ready
  );
  modport sink (
    input  valid, op, start_ok, ready_ok, read_ok, raw_sample, req_points,
    output ready
  );
endinterface

[hdl/scsr_out_if.sv]
// ----------------------------------------------------------------------------
// scsr_out_if
// Output channel: one result item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scsr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [scsr_pkg::SAMPLE_W-1:0] point_value;
  logic                                 point_valid;
  logic                                 last;
  logic [scsr_pkg::POINTS_W-1:0]        points_held;
  logic [scsr_pkg::PHASE_W-1:0]         conv_state;
  logic [scsr_pkg::CMD_W-1:0]           commands_issued;
  logic                                 temp_updated;
  logic                                 update_error;
  logic                                 temp_changed;
  logic signed [scsr_pkg::SAMPLE_W-1:0] latest_temp;

  modport source (
    output valid, point_value, point_valid, last, points_held, conv_state,
           commands_issued, temp_updated, update_error, temp_changed, latest_temp,
    input  ready
  );
  modport sink (
    input  valid, point_value, point_valid, last, points_held, conv_state,
           commands_issued, temp_updated, update_error, temp_changed, latest_temp,
    output ready
  );
endinterface

[hdl/sensor_conversion_sequencer_ring.sv]
// ----------------------------------------------------------------------------
// sensor_conversion_sequencer_ring
// Periodic conversion sequencer with a 16-entry sample ring. Request items
// pass through a two-entry queue into one execute stage that also drives the
// registered result channel. Tick, handler-step and empty-buffer items give
// one result each; a read request gives one per point it returns (1 to 15,
// one result when nothing is returned), one point per cycle unless the result
// channel stalls, and blocks new items until its burst ends. An item passes
// its queue slot, then the result register. The user must write update_period
// through cfg_we_i/cfg_wdata_i while no item is in flight; it is not checked.
// ----------------------------------------------------------------------------
module sensor_conversion_sequencer_ring (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  scsr_in_if.sink                       in_i,
  scsr_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [scsr_pkg::PERIOD_W-1:0] cfg_wdata_i
);

  logic [scsr_pkg::PERIOD_W-1:0] update_period_q;
  logic                          item_valid;
  logic                          item_ready;
  scsr_pkg::item_t               item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      update_period_q <= scsr_pkg::PERIOD_RESET;
    end else if (cfg_we_i) begin
      update_period_q <= cfg_wdata_i;
    end
  end

  scsr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  scsr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .update_period_i (update_period_q),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_ready_o    (item_ready),
    .out_o           (out_o)
  );

endmodule

[hdl/scsr_front.sv]
// ----------------------------------------------------------------------------
// scsr_front
// Accepts request items, decodes the opcode, clamps the point limit and
// holds them in a two-entry queue for the execute stage.
// ----------------------------------------------------------------------------
module scsr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  scsr_in_if.sink          in_i,
  output logic             item_valid_o,
  output scsr_pkg::item_t  item_o,
  input  logic             item_ready_i
);

  scsr_pkg::item_t                   slot_q [scsr_pkg::QUEUE_DEPTH];
  logic [scsr_pkg::QPTR_W-1:0]       wr_sel_q, wr_sel_d;
  logic [scsr_pkg::QPTR_W-1:0]       rd_sel_q, rd_sel_d;
  logic [scsr_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              push, pop;
  scsr_pkg::item_t                   new_item;

  assign in_i.ready   = (cnt_q != scsr_pkg::QCNT_W'(scsr_pkg::QUEUE_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = slot_q[rd_sel_q];

  assign push = in_i.valid && in_i.ready;
  assign pop  = item_valid_o && item_ready_i;

  always_comb begin
    new_item.op         = scsr_pkg::op_e'(in_i.op);
    new_item.start_ok   = in_i.start_ok;
    new_item.ready_ok   = in_i.ready_ok;
    new_item.read_ok    = in_i.read_ok;
    new_item.raw_sample = in_i.raw_sample;
    // requests above the result limit are served as the limit
    new_item.lim        = (in_i.req_points > scsr_pkg::MAX_POINTS) ?
                          scsr_pkg::MAX_POINTS : in_i.req_points;
  end

  always_comb begin
    wr_sel_d = wr_sel_q;
    rd_sel_d = rd_sel_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_sel_d = (wr_sel_q == scsr_pkg::QPTR_W'(scsr_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_sel_q + 1'b1;
    end
    if (pop) begin
      rd_sel_d = (rd_sel_q == scsr_pkg::QPTR_W'(scsr_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_sel_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_sel_q <= '0;
      rd_sel_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_sel_q <= wr_sel_d;
      rd_sel_q <= rd_sel_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_sel_q] <= new_item;
    end
  end

endmodule

[hdl/scsr_back.sv]
// ----------------------------------------------------------------------------
// scsr_back
// Execute stage: conversion sequencer, sample ring, read-out bursts and the
// result register.
// ----------------------------------------------------------------------------
module scsr_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [scsr_pkg::PERIOD_W-1:0]   update_period_i,
  input  logic                            item_valid_i,
  input  scsr_pkg::item_t                 item_i,
  output logic                            item_ready_o,
  scsr_out_if.source                      out_o
);

  // sequencer state
  scsr_pkg::phase_e                    phase_q, phase_d;
  logic [scsr_pkg::DELAY_W-1:0]        delay_q, delay_d;
  logic [scsr_pkg::PERIOD_W-1:0]       period_q, period_d;
  logic [scsr_pkg::RETRY_W-1:0]        retries_q, retries_d;
  logic signed [scsr_pkg::SAMPLE_W-1:0] last_temp_q, last_temp_d;

  // ring
  logic signed [scsr_pkg::SAMPLE_W-1:0] ring_q [scsr_pkg::RING_DEPTH];
  logic [scsr_pkg::PTR_W-1:0]          wr_q, wr_d;
  logic [scsr_pkg::PTR_W-1:0]          rd_q, rd_d;
  logic                                ring_we;

  // read-out burst
  logic                                burst_q, burst_d;
  logic [scsr_pkg::MAXP_W-1:0]         left_q, left_d;

  // result register
  logic                                out_valid_q, out_valid_d;
  logic signed [scsr_pkg::SAMPLE_W-1:0] r_value_q;
  logic                                r_valid_q, r_last_q;
  logic [scsr_pkg::POINTS_W-1:0]       r_held_q;
  logic [scsr_pkg::PHASE_W-1:0]        r_state_q;
  logic [scsr_pkg::CMD_W-1:0]          r_cmds_q;
  logic                                r_upd_q, r_err_q, r_chg_q;
  logic signed [scsr_pkg::SAMPLE_W-1:0] r_latest_q;

  // working values of one step
  logic                                ld, emit;
  logic signed [scsr_pkg::SAMPLE_W-1:0] r_value;
  logic                                r_valid, r_last, r_upd, r_err, r_chg;
  logic [scsr_pkg::CMD_W-1:0]          r_cmds;
  scsr_pkg::phase_e                    ph;
  logic [scsr_pkg::RETRY_W-1:0]        ret;
  logic                                do_read;
  logic [scsr_pkg::PTR_W-1:0]          held_now, held_next;
  logic [scsr_pkg::CMP_W-1:0]          held_ext, lim_ext;
  logic [scsr_pkg::MAXP_W-1:0]         n;

  assign ld           = !out_valid_q || out_o.ready;
  assign item_ready_o = !burst_q && ld;

  assign held_now = scsr_pkg::held_count(wr_q, rd_q);
  assign held_ext = scsr_pkg::CMP_W'(held_now);
  assign lim_ext  = scsr_pkg::CMP_W'(item_i.lim);
  assign n        = scsr_pkg::MAXP_W'((held_ext < lim_ext) ? held_ext : lim_ext);

  always_comb begin
    phase_d     = phase_q;
    delay_d     = delay_q;
    period_d    = period_q;
    retries_d   = retries_q;
    last_temp_d = last_temp_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    burst_d     = burst_q;
    left_d      = left_q;
    ring_we     = 1'b0;
    emit        = 1'b0;
    r_value     = '0;
    r_valid     = 1'b0;
    r_last      = 1'b1;
    r_cmds      = '0;
    r_upd       = 1'b0;
    r_err       = 1'b0;
    r_chg       = 1'b0;
    ph          = phase_q;
    ret         = retries_q;
    do_read     = 1'b0;

    if (burst_q) begin
      if (ld) begin
        emit    = 1'b1;
        r_value = ring_q[rd_q];
        r_valid = 1'b1;
        r_last  = (left_q == scsr_pkg::MAXP_W'(1));
        rd_d    = scsr_pkg::ptr_next(rd_q);
        left_d  = left_q - 1'b1;
        burst_d = (left_q != scsr_pkg::MAXP_W'(1));
      end
    end else if (item_valid_i && ld) begin
      emit = 1'b1;
      unique case (item_i.op)
        scsr_pkg::OP_TICK: begin
          if (delay_q != '0) begin
            delay_d = delay_q - 1'b1;
          end
          if (period_q != '0) begin
            period_d = period_q - 1'b1;
          end
        end
        scsr_pkg::OP_STEP: begin
          if (delay_q == '0) begin
            if (period_q == '0) begin
              period_d = update_period_i;
              if (ph == scsr_pkg::PH_IDLE) begin
                ph = scsr_pkg::PH_STARTING;
              end
            end
            unique case (ph)
              scsr_pkg::PH_STARTING: begin
                r_cmds[scsr_pkg::CMD_START] = 1'b1;
                if (item_i.start_ok) begin
                  ret = scsr_pkg::RETRY_MAX;
                  ph  = scsr_pkg::PH_STARTED;
                end
                delay_d = scsr_pkg::DELAY_LONG;
              end
              scsr_pkg::PH_STARTED: begin
                if (ret == '0) begin
                  r_err = 1'b1;
                  ph    = scsr_pkg::PH_IDLE;
                end else begin
                  r_cmds[scsr_pkg::CMD_POLL] = 1'b1;
                  if (!item_i.ready_ok) begin
                    delay_d = scsr_pkg::DELAY_LONG;
                    ret     = ret - 1'b1;
                  end else begin
                    // a good poll goes straight on to the read
                    ret     = scsr_pkg::RETRY_MAX;
                    ph      = scsr_pkg::PH_COMPLETE;
                    do_read = 1'b1;
                  end
                end
              end
              scsr_pkg::PH_COMPLETE: begin
                do_read = 1'b1;
              end
              default: begin
              end
            endcase
            if (do_read) begin
              if (ret == '0) begin
                r_err = 1'b1;
                ph    = scsr_pkg::PH_IDLE;
              end else begin
                r_cmds[scsr_pkg::CMD_READ] = 1'b1;
                if (!item_i.read_ok) begin
                  delay_d = scsr_pkg::DELAY_SHORT;
                  ret     = ret - 1'b1;
                end else begin
                  r_upd       = 1'b1;
                  ring_we     = 1'b1;
                  wr_d        = scsr_pkg::ptr_next(wr_q);
                  ph          = scsr_pkg::PH_IDLE;
                  r_chg       = (item_i.raw_sample != last_temp_q);
                  last_temp_d = item_i.raw_sample;
                end
              end
            end
            phase_d   = ph;
            retries_d = ret;
          end
        end
        scsr_pkg::OP_READ: begin
          if (n != '0) begin
            r_value = ring_q[rd_q];
            r_valid = 1'b1;
            r_last  = (n == scsr_pkg::MAXP_W'(1));
            rd_d    = scsr_pkg::ptr_next(rd_q);
            left_d  = n - 1'b1;
            burst_d = (n != scsr_pkg::MAXP_W'(1));
          end
        end
        scsr_pkg::OP_FLUSH: begin
          rd_d = wr_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign held_next = scsr_pkg::held_count(wr_d, rd_d);

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= scsr_pkg::PH_IDLE;
      delay_q     <= '0;
      period_q    <= '0;
      retries_q   <= '0;
      last_temp_q <= '0;
      wr_q        <= '0;
      rd_q        <= '0;
      burst_q     <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      delay_q     <= delay_d;
      period_q    <= period_d;
      retries_q   <= retries_d;
      last_temp_q <= last_temp_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      burst_q     <= burst_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[wr_q] <= item_i.raw_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      r_value_q  <= r_value;
      r_valid_q  <= r_valid;
      r_last_q   <= r_last;
      r_held_q   <= scsr_pkg::POINTS_W'(held_next);
      r_state_q  <= scsr_pkg::phase_code(phase_d);
      r_cmds_q   <= r_cmds;
      r_upd_q    <= r_upd;
      r_err_q    <= r_err;
      r_chg_q    <= r_chg;
      r_latest_q <= last_temp_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.point_value     = r_value_q;
  assign out_o.point_valid     = r_valid_q;
  assign out_o.last            = r_last_q;
  assign out_o.points_held     = r_held_q;
  assign out_o.conv_state      = r_state_q;
  assign out_o.commands_issued = r_cmds_q;
  assign out_o.temp_updated    = r_upd_q;
  assign out_o.update_error    = r_err_q;
  assign out_o.temp_changed    = r_chg_q;
  assign out_o.latest_temp     = r_latest_q;

endmodule

[tb/sv/scsr_result_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsr_result_check
// Watches both channels of the conversion sequencer and ring, runs its own
// model of the sequencer state and sample ring on every accepted request
// item, and compares each result item with the oldest outstanding one.
// ----------------------------------------------------------------------------
module scsr_result_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  scsr_in_if                            in_mon_i,
  scsr_out_if                           out_mon_i,
  input  logic                          cfg_we_i,
  input  logic [scsr_pkg::PERIOD_W-1:0] cfg_wdata_i,
  output int                            mismatches_o,
  output int                            outstanding_o
);

  typedef struct packed {
    logic signed [scsr_pkg::SAMPLE_W-1:0] value;
    logic                                 point_ok;
    logic                                 last;
    logic [scsr_pkg::POINTS_W-1:0]        held;
    logic [scsr_pkg::PHASE_W-1:0]         state;
    logic [scsr_pkg::CMD_W-1:0]           cmds;
    logic                                 stored;
    logic                                 failed;
    logic                                 changed;
    logic signed [scsr_pkg::SAMPLE_W-1:0] latest;
  } point_rec_t;

  point_rec_t                    expected_q[$];
  int                            mismatches;

  logic [scsr_pkg::PERIOD_W-1:0] period_reg;
  logic [scsr_pkg::PERIOD_W-1:0] period_cnt;
  logic [scsr_pkg::DELAY_W-1:0]  delay_cnt;
  logic [scsr_pkg::RETRY_W-1:0]  retries;
  logic [scsr_pkg::PHASE_W-1:0]  phase;
  logic [scsr_pkg::SAMPLE_W-1:0] ring [scsr_pkg::RING_DEPTH];
  logic [scsr_pkg::PTR_W-1:0]    wr_ptr;
  logic [scsr_pkg::PTR_W-1:0]    rd_ptr;
  logic [scsr_pkg::SAMPLE_W-1:0] last_sample;

  function automatic string show_point(input point_rec_t p);
    return $sformatf({"value %0d valid %b last %b held %0d state %0d cmds %b",
                      " upd %b err %b chg %b latest %0d"},
                     p.value, p.point_ok, p.last, p.held, p.state, p.cmds,
                     p.stored, p.failed, p.changed, p.latest);
  endfunction

  task automatic push_point(input logic [scsr_pkg::SAMPLE_W-1:0] value,
                            input logic point_ok, input logic last,
                            input logic [scsr_pkg::CMD_W-1:0] cmds,
                            input logic stored, input logic failed, input logic changed);
    point_rec_t rec;
    rec.value    = value;
    rec.point_ok = point_ok;
    rec.last     = last;
    rec.held     = wr_ptr - rd_ptr;
    rec.state    = phase;
    rec.cmds     = cmds;
    rec.stored   = stored;
    rec.failed   = failed;
    rec.changed  = changed;
    rec.latest   = last_sample;
    expected_q.push_back(rec);
  endtask

  task automatic predict_item(input scsr_pkg::op_e op, input logic start_ok,
                              input logic ready_ok, input logic read_ok,
                              input logic [scsr_pkg::SAMPLE_W-1:0] raw,
                              input logic [scsr_pkg::MAXP_W-1:0] max_pts);
    logic [scsr_pkg::CMD_W-1:0] cmds;
    logic                       stored;
    logic                       failed;
    logic                       changed;
    logic                       fetch;
    logic [scsr_pkg::PTR_W-1:0] held;
    int unsigned                want;
    int unsigned                count;
    cmds    = '0;
    stored  = 1'b0;
    failed  = 1'b0;
    changed = 1'b0;
    fetch   = 1'b0;
    unique case (op)
      scsr_pkg::OP_TICK: begin
        if (delay_cnt != '0) delay_cnt = delay_cnt - 1'b1;
        if (period_cnt != '0) period_cnt = period_cnt - 1'b1;
      end
      scsr_pkg::OP_STEP: begin
        if (delay_cnt == '0) begin
          if (period_cnt == '0) begin
            period_cnt = period_reg;
            if (phase == scsr_pkg::CODE_IDLE) phase = scsr_pkg::CODE_STARTING;
          end
          unique case (phase)
            scsr_pkg::CODE_STARTING: begin
              cmds[scsr_pkg::CMD_START] = 1'b1;
              if (start_ok) begin
                retries = scsr_pkg::RETRY_MAX;
                phase   = scsr_pkg::CODE_STARTED;
              end
              delay_cnt = scsr_pkg::DELAY_LONG;
            end
            scsr_pkg::CODE_STARTED: begin
              if (retries == '0) begin
                failed = 1'b1;
                phase  = scsr_pkg::CODE_IDLE;
              end else begin
                cmds[scsr_pkg::CMD_POLL] = 1'b1;
                if (!ready_ok) begin
                  delay_cnt = scsr_pkg::DELAY_LONG;
                  retries   = retries - 1'b1;
                end else begin
                  // good poll goes straight on to the read
                  retries = scsr_pkg::RETRY_MAX;
                  phase   = scsr_pkg::CODE_COMPLETE;
                  fetch   = 1'b1;
                end
              end
            end
            scsr_pkg::CODE_COMPLETE: fetch = 1'b1;
            default: ;
          endcase
          if (fetch) begin
            if (retries == '0) begin
              failed = 1'b1;
              phase  = scsr_pkg::CODE_IDLE;
            end else begin
              cmds[scsr_pkg::CMD_READ] = 1'b1;
              if (!read_ok) begin
                delay_cnt = scsr_pkg::DELAY_SHORT;
                retries   = retries - 1'b1;
              end else begin
                stored       = 1'b1;
                ring[wr_ptr] = raw;
                wr_ptr       = wr_ptr + 1'b1;
                phase        = scsr_pkg::CODE_IDLE;
                changed      = (raw != last_sample);
                last_sample  = raw;
              end
            end
          end
        end
      end
      scsr_pkg::OP_READ: begin
        want  = 32'((max_pts > scsr_pkg::MAX_POINTS) ? scsr_pkg::MAX_POINTS : max_pts);
        held  = wr_ptr - rd_ptr;
        count = 32'(held);
        if (want < count) count = want;
        if (count == 0) begin
          push_point('0, 1'b0, 1'b1, '0, 1'b0, 1'b0, 1'b0);
          return;
        end
        for (int unsigned k = 0; k < count; k++) begin
          rd_ptr = rd_ptr + 1'b1;
          push_point(ring[rd_ptr - 1'b1], 1'b1, k + 1 == count, '0, 1'b0, 1'b0, 1'b0);
        end
        return;
      end
      default: rd_ptr = wr_ptr;
    endcase
    push_point('0, 1'b0, 1'b1, cmds, stored, failed, changed);
  endtask

  task automatic check_point();
    point_rec_t want;
    point_rec_t got;
    got.value    = out_mon_i.point_value;
    got.point_ok = out_mon_i.point_valid;
    got.last     = out_mon_i.last;
    got.held     = out_mon_i.points_held;
    got.state    = out_mon_i.conv_state;
    got.cmds     = out_mon_i.commands_issued;
    got.stored   = out_mon_i.temp_updated;
    got.failed   = out_mon_i.update_error;
    got.changed  = out_mon_i.temp_changed;
    got.latest   = out_mon_i.latest_temp;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: unexpected result item: %s", $time, show_point(got));
      return;
    end
    want = expected_q.pop_front();
    if (got.value !== want.value || got.point_ok !== want.point_ok ||
        got.last !== want.last || got.held !== want.held || got.state !== want.state ||
        got.cmds !== want.cmds || got.stored !== want.stored ||
        got.failed !== want.failed || got.changed !== want.changed ||
        got.latest !== want.latest) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result mismatch\n  expected %s\n  actual   %s", $time,
                 show_point(want), show_point(got));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      mismatches  = 0;
      period_reg  = scsr_pkg::PERIOD_RESET;
      period_cnt  = '0;
      delay_cnt   = '0;
      retries     = '0;
      phase       = scsr_pkg::CODE_IDLE;
      wr_ptr      = '0;
      rd_ptr      = '0;
      last_sample = '0;
      for (int i = 0; i < scsr_pkg::RING_DEPTH; i++) ring[i] = '0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) period_reg = cfg_wdata_i;
      if (out_mon_i.valid && out_mon_i.ready) check_point();
      if (in_mon_i.valid && in_mon_i.ready) begin
        predict_item(scsr_pkg::op_e'(in_mon_i.op), in_mon_i.start_ok, in_mon_i.ready_ok,
                     in_mon_i.read_ok, in_mon_i.raw_sample, in_mon_i.req_points);
      end
      mismatches_o  <= mismatches;
      outstanding_o <= expected_q.size();
    end
  end

endmodule

[tb/sv/sensor_conversion_sequencer_ring_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_conversion_sequencer_ring_test
// Drives request items into the sequencer and ring: empty reads and flush,
// one conversion with a failed read and a retry under a long result stall,
// a zero update period, then a few random items, with random gaps on both
// channels.
// ----------------------------------------------------------------------------
module sensor_conversion_sequencer_ring_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [scsr_pkg::PERIOD_W-1:0] cfg_wdata;
  logic                          calm;
  logic                          hold_req;
  logic                          running;
  int                            quiet_cycles;
  int                            mismatches;
  int                            outstanding;

  scsr_in_if  in_ch ();
  scsr_out_if out_ch ();

  sensor_conversion_sequencer_ring i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  scsr_result_check i_result_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_mon_i      (in_ch),
    .out_mon_i     (out_ch),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_item(input scsr_pkg::op_e op, input logic start_ok,
                           input logic ready_ok, input logic read_ok,
                           input logic [scsr_pkg::SAMPLE_W-1:0] raw,
                           input logic [scsr_pkg::MAXP_W-1:0] max_pts);
    while (!calm && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.start_ok   <= start_ok;
    in_ch.ready_ok   <= ready_ok;
    in_ch.read_ok    <= read_ok;
    in_ch.raw_sample <= raw;
    in_ch.req_points <= max_pts;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic ticks(input int unsigned count);
    repeat (count) begin
      send_item(scsr_pkg::OP_TICK, coin(), coin(), coin(),
                scsr_pkg::SAMPLE_W'($urandom),
                scsr_pkg::MAXP_W'($urandom_range(0, 31)));
    end
  endtask

  task automatic handler(input logic start_ok, input logic ready_ok, input logic read_ok,
                         input logic [scsr_pkg::SAMPLE_W-1:0] raw);
    send_item(scsr_pkg::OP_STEP, start_ok, ready_ok, read_ok, raw,
              scsr_pkg::MAXP_W'($urandom_range(0, 31)));
  endtask

  task automatic read_points(input logic [scsr_pkg::MAXP_W-1:0] max_pts);
    send_item(scsr_pkg::OP_READ, coin(), coin(), coin(),
              scsr_pkg::SAMPLE_W'($urandom), max_pts);
  endtask

  task automatic empty_ring();
    send_item(scsr_pkg::OP_FLUSH, coin(), coin(), coin(),
              scsr_pkg::SAMPLE_W'($urandom),
              scsr_pkg::MAXP_W'($urandom_range(0, 31)));
  endtask

  // the register only changes once every result is out
  task automatic write_period(input logic [scsr_pkg::PERIOD_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= calm || $urandom_range(99) >= 20;
    end
  end

  always @(posedge clk) begin
    if (!running || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    calm             <= 1'b0;
    hold_req         <= 1'b0;
    running          <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= scsr_pkg::OP_TICK;
    in_ch.start_ok   <= 1'b0;
    in_ch.ready_ok   <= 1'b0;
    in_ch.read_ok    <= 1'b0;
    in_ch.raw_sample <= '0;
    in_ch.req_points <= '0;
    repeat (7) @(posedge clk);
    rst_n   <= 1'b1;
    running <= 1'b1;

    // nothing held yet: empty reads and a flush
    read_points(scsr_pkg::MAXP_W'(0));
    read_points(scsr_pkg::MAXP_W'(31));
    empty_ring();

    // short period, start accepted at once
    write_period(scsr_pkg::PERIOD_W'(3));
    handler(1'b1, 1'b0, 1'b0, 16'h1234);
    ticks(40);

    // receiver holds off while ticks keep coming, no gaps after that
    calm     <= 1'b1;
    hold_req <= 1'b1;
    ticks(60);
    calm     <= 1'b0;

    // good poll falls through to a failed read, then the short delay
    handler(1'b0, 1'b1, 1'b0, 16'h1234);
    handler(1'b1, 1'b1, 1'b1, 16'h1234);
    ticks(10);
    handler(1'b0, 1'b0, 1'b1, 16'h8000);

    // zero period: the next step after the counter runs out starts again
    write_period('0);
    ticks(3);
    handler(1'b0, 1'b1, 1'b1, '0);
    read_points(scsr_pkg::MAXP_W'(16));
    read_points(scsr_pkg::MAXP_W'(5));

    repeat (4) begin
      send_item(scsr_pkg::op_e'($urandom_range(0, 3)), coin(), coin(), coin(),
                scsr_pkg::SAMPLE_W'($urandom), scsr_pkg::MAXP_W'($urandom_range(0, 31)));
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sensor_conversion_sequencer_ring.f]
hdl/scsr_pkg.sv
hdl/scsr_in_if.sv
hdl/scsr_out_if.sv
hdl/scsr_front.sv
hdl/scsr_back.sv
hdl/sensor_conversion_sequencer_ring.sv
tb/sv/scsr_result_check.sv
tb/sv/sensor_conversion_sequencer_ring_test.sv
